// ===== hdl/lchs_pkg.sv =====
// Package with the sizes, action codes and record types of the light cone history search.
package lchs_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] frame_time;
        logic signed [31:0] imp_x;
        logic signed [31:0] imp_y;
        logic signed [31:0] imp_z;
        logic signed [31:0] proper_time;
    } lchs_cmd_t;

    typedef struct packed {
        logic               seen;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_time;
        logic signed [31:0] out_imp_x;
        logic signed [31:0] out_imp_y;
        logic signed [31:0] out_imp_z;
        logic signed [31:0] out_proper;
    } lchs_result_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] t;
        logic signed [31:0] imp_x;
        logic signed [31:0] imp_y;
        logic signed [31:0] imp_z;
        logic signed [31:0] proper;
    } lchs_event_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] t;
    } lchs_point_t;

endpackage

// ===== hdl/light_cone_history_search.sv =====
// Top level of the light cone history search: sequencer, history pointers and result register.
//
//  Channel   Signals              Direction  Beat taken when
//  command   start, busy, cmd     in         start && !busy
//  result    done, result         out        done (one cycle, no hold-off)
//
// Init and append hold busy through S_PUSH, or through S_PUSH_FIRST and then S_PUSH when the
// history is empty, and the next command can be taken once they are back in idle.
// A query first tests the start event, then makes p probes, where p is at most ceil(log2(n))
// for n stored events; each probe is one history memory read plus the four stage cone test
// pipeline. On an empty history only the start event is tested before done.
// Reset empties the history and clears the start event; busy is low right after it.
// The result is shown for exactly one cycle and a new command may be taken in that cycle.
module light_cone_history_search
    import lchs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  lchs_cmd_t    cmd,
    output logic         done,
    output lchs_result_t result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_FIRST,
        S_PUSH,
        S_SEEN_GO,
        S_SEEN_WAIT,
        S_LOOP,
        S_PROBE_FEED,
        S_PROBE_WAIT,
        S_FETCH
    } state_t;

    function automatic logic [HIST_AW-1:0] wrap_slot(input logic [HIST_AW-1:0] base,
                                                     input logic [CNT_W-1:0] offs);
        logic [CNT_W+1:0] sum;
        sum = (CNT_W + 2)'(base) + (CNT_W + 2)'(offs);
        if (sum >= (CNT_W + 2)'(HIST_DEPTH))
        begin
            sum = sum - (CNT_W + 2)'(HIST_DEPTH);
        end
        return sum[HIST_AW-1:0];
    endfunction

    state_t       state_reg;
    lchs_point_t  start_reg;
    lchs_point_t  obs_reg;
    lchs_event_t  ev_reg;
    logic [1:0]   act_reg;
    logic [HIST_AW-1:0] oldest_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg, mid_reg;
    logic         seen_reg;
    lchs_result_t result_reg;
    logic         done_reg;

    logic [HIST_AW-1:0] push_slot;
    logic [HIST_AW-1:0] oldest_next;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   span;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic               wr_en;
    lchs_event_t        wr_data;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    lchs_event_t        rd_data;
    logic               cone_valid;
    lchs_point_t        cone_evt;
    logic               cone_done;
    logic               cone_hit;

    always_comb
    begin
        if (count_reg < CNT_W'(HIST_DEPTH))
        begin
            push_slot   = wrap_slot(oldest_reg, count_reg);
            oldest_next = oldest_reg;
            count_next  = count_reg + CNT_W'(1);
        end
        else
        begin
            push_slot   = oldest_reg;
            oldest_next = wrap_slot(oldest_reg, CNT_W'(1));
            count_next  = count_reg;
        end
    end

    assign span    = hi_reg - lo_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    assign wr_en = (state_reg == S_PUSH_FIRST) || (state_reg == S_PUSH);

    always_comb
    begin
        wr_data = ev_reg;
        if (state_reg == S_PUSH_FIRST && act_reg == ACT_APPEND)
        begin
            wr_data = '{x: start_reg.x, y: start_reg.y, z: start_reg.z, t: start_reg.t,
                        imp_x: '0, imp_y: '0, imp_z: '0, proper: '0};
        end
    end

    assign rd_en   = (state_reg == S_LOOP);
    assign rd_addr = (span > CNT_W'(1)) ? wrap_slot(oldest_reg, mid)
                                        : wrap_slot(oldest_reg, lo_reg);

    assign cone_valid = (state_reg == S_SEEN_GO) || (state_reg == S_PROBE_FEED);
    assign cone_evt   = (state_reg == S_SEEN_GO) ? start_reg
                      : lchs_point_t'{x: rd_data.x, y: rd_data.y, z: rd_data.z, t: rd_data.t};

    lchs_hist_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (push_slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lchs_cone u_cone (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cone_valid),
        .obs      (obs_reg),
        .evt      (cone_evt),
        .done     (cone_done),
        .hit      (cone_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            start_reg  <= '0;
            obs_reg    <= '0;
            ev_reg     <= '0;
            act_reg    <= ACT_INIT;
            oldest_reg <= '0;
            count_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            seen_reg   <= 1'b0;
            result_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ev_reg  <= '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                                     t: cmd.frame_time, imp_x: cmd.imp_x, imp_y: cmd.imp_y,
                                     imp_z: cmd.imp_z, proper: cmd.proper_time};
                        act_reg <= cmd.action;
                        case (cmd.action)
                            ACT_INIT:
                            begin
                                start_reg <= '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                                               t: cmd.frame_time};
                                state_reg <= (count_reg == '0) ? S_PUSH_FIRST : S_PUSH;
                            end
                            ACT_APPEND:
                            begin
                                state_reg <= (count_reg == '0) ? S_PUSH_FIRST : S_PUSH;
                            end
                            ACT_QUERY:
                            begin
                                obs_reg   <= '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z,
                                               t: cmd.frame_time};
                                state_reg <= S_SEEN_GO;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PUSH_FIRST:
                begin
                    oldest_reg <= oldest_next;
                    count_reg  <= count_next;
                    state_reg  <= S_PUSH;
                end
                S_PUSH:
                begin
                    oldest_reg <= oldest_next;
                    count_reg  <= count_next;
                    state_reg  <= S_IDLE;
                end
                S_SEEN_GO:
                begin
                    state_reg <= S_SEEN_WAIT;
                end
                S_SEEN_WAIT:
                begin
                    if (cone_done)
                    begin
                        seen_reg <= cone_hit;
                        lo_reg   <= '0;
                        hi_reg   <= count_reg;
                        if (count_reg == '0)
                        begin
                            result_reg <= lchs_result_t'{seen: cone_hit, default: '0};
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_LOOP;
                        end
                    end
                end
                S_LOOP:
                begin
                    mid_reg   <= mid;
                    state_reg <= (span > CNT_W'(1)) ? S_PROBE_FEED : S_FETCH;
                end
                S_PROBE_FEED:
                begin
                    state_reg <= S_PROBE_WAIT;
                end
                S_PROBE_WAIT:
                begin
                    if (cone_done)
                    begin
                        if (cone_hit)
                        begin
                            lo_reg <= mid_reg;
                        end
                        else
                        begin
                            hi_reg <= mid_reg;
                        end
                        state_reg <= S_LOOP;
                    end
                end
                S_FETCH:
                begin
                    result_reg <= '{seen: seen_reg, out_x: rd_data.x, out_y: rd_data.y,
                                    out_z: rd_data.z, out_time: rd_data.t,
                                    out_imp_x: rd_data.imp_x, out_imp_y: rd_data.imp_y,
                                    out_imp_z: rd_data.imp_z, out_proper: rd_data.proper};
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/lchs_hist_mem.sv =====
// Event history memory with one write port and one registered read port.
module lchs_hist_mem
    import lchs_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [HIST_AW-1:0] wr_addr,
    input  lchs_event_t        wr_data,
    input  logic               rd_en,
    input  logic [HIST_AW-1:0] rd_addr,
    output lchs_event_t        rd_data
);

    lchs_event_t mem_q [HIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_q[rd_addr];
        end
    end

endmodule

// ===== hdl/lchs_cone.sv =====
// Four stage pipelined past light cone test of one event against an observer.
module lchs_cone
    import lchs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  lchs_point_t obs,
    input  lchs_point_t evt,
    output logic        done,
    output logic        hit
);

    function automatic logic [31:0] mag33(input logic [32:0] d);
        logic [32:0] a;
        a = d[32] ? (~d + 33'd1) : d;
        return a[31:0];
    endfunction

    logic [32:0] dx, dy, dz, dt;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, done_reg;
    logic [31:0] mag_x_reg, mag_y_reg, mag_z_reg, mag_t_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [63:0] sq_x_reg, sq_y_reg, sq_z_reg, sq_t2_reg, sq_t3_reg;
    logic [65:0] sum_reg;
    logic        hit_reg;

    logic [63:0] sq_x, sq_y, sq_z, sq_t;

    assign dx = {obs.x[31], obs.x} - {evt.x[31], evt.x};
    assign dy = {obs.y[31], obs.y} - {evt.y[31], evt.y};
    assign dz = {obs.z[31], obs.z} - {evt.z[31], evt.z};
    assign dt = {obs.t[31], obs.t} - {evt.t[31], evt.t};

    assign sq_x = mag_x_reg * mag_x_reg;
    assign sq_y = mag_y_reg * mag_y_reg;
    assign sq_z = mag_z_reg * mag_z_reg;
    assign sq_t = mag_t_reg * mag_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg <= mag33(dx);
        mag_y_reg <= mag33(dy);
        mag_z_reg <= mag33(dz);
        mag_t_reg <= dt[31:0];
        neg1_reg  <= dt[32];

        sq_x_reg  <= sq_x;
        sq_y_reg  <= sq_y;
        sq_z_reg  <= sq_z;
        sq_t2_reg <= sq_t;
        neg2_reg  <= neg1_reg;

        sum_reg   <= 66'(sq_x_reg) + 66'(sq_y_reg) + 66'(sq_z_reg);
        sq_t3_reg <= sq_t2_reg;
        neg3_reg  <= neg2_reg;

        hit_reg   <= !neg3_reg && (sum_reg <= 66'(sq_t3_reg));
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

// ===== dv/tb_light_cone_history_search.sv =====
// Self-checking testbench for the light cone history search block.
`timescale 1ns / 100ps

module tb_light_cone_history_search;
    import lchs_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         FIX_MIN      = 32'sh8000_0000;
    localparam int         FIX_MAX      = 32'sh7FFF_FFFF;
    localparam int         ONE          = 32'sh0001_0000;
    localparam int         RANDOM_ITEMS = 1930;
    localparam int         CYCLE_LIMIT  = 1_000_000;

    logic         clk;
    logic         rst_n;
    logic         start = 1'b0;
    logic         busy;
    lchs_cmd_t    cmd = '0;
    logic         done;
    lchs_result_t result;

    lchs_cmd_t    command_queue[$];
    lchs_result_t pending_finds[$];

    lchs_point_t  cone_origin;
    lchs_event_t  hist_mem[HIST_DEPTH];
    int           hist_head;
    int           hist_count;

    logic         cmd_taken = 1'b0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    int           tx, ty, tz, tt;

    light_cone_history_search uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit in_past_cone(lchs_point_t obs, logic signed [31:0] ex,
                                        logic signed [31:0] ey, logic signed [31:0] ez,
                                        logic signed [31:0] et);
        logic signed [33:0] dx, dy, dz, dt;
        logic signed [67:0] dist2, reach2;
        dx = obs.x - ex;
        dy = obs.y - ey;
        dz = obs.z - ez;
        dt = obs.t - et;
        if (dt < 0)
        begin
            return 1'b0;
        end
        dist2  = dx * dx + dy * dy + dz * dz;
        reach2 = dt * dt;
        return dist2 <= reach2;
    endfunction

    function automatic void push_history(lchs_event_t ev);
        int slot;
        if (hist_count < HIST_DEPTH)
        begin
            slot = (hist_head + hist_count) % HIST_DEPTH;
            hist_count++;
        end
        else
        begin
            slot = hist_head;
            hist_head = (hist_head + 1) % HIST_DEPTH;
        end
        hist_mem[slot] = ev;
    endfunction

    function automatic void queue_cmd(lchs_cmd_t c);
        command_queue = {command_queue, c};
    endfunction

    function automatic void update_history_and_search(lchs_cmd_t c);
        lchs_event_t  ev;
        lchs_event_t  first;
        lchs_event_t  probe;
        lchs_point_t  obs;
        lchs_result_t found;
        int           lo, hi, mid;
        ev.x      = c.pos_x;
        ev.y      = c.pos_y;
        ev.z      = c.pos_z;
        ev.t      = c.frame_time;
        ev.imp_x  = c.imp_x;
        ev.imp_y  = c.imp_y;
        ev.imp_z  = c.imp_z;
        ev.proper = c.proper_time;
        case (c.action)
            ACT_INIT, ACT_APPEND:
            begin
                if (c.action == ACT_INIT)
                begin
                    cone_origin.x = c.pos_x;
                    cone_origin.y = c.pos_y;
                    cone_origin.z = c.pos_z;
                    cone_origin.t = c.frame_time;
                end
                if (hist_count == 0)
                begin
                    first   = '0;
                    first.x = cone_origin.x;
                    first.y = cone_origin.y;
                    first.z = cone_origin.z;
                    first.t = cone_origin.t;
                    if (c.action == ACT_INIT)
                    begin
                        first = ev;
                    end
                    push_history(first);
                end
                push_history(ev);
            end
            ACT_QUERY:
            begin
                obs.x = c.pos_x;
                obs.y = c.pos_y;
                obs.z = c.pos_z;
                obs.t = c.frame_time;
                found = '0;
                found.seen = in_past_cone(obs, cone_origin.x, cone_origin.y, cone_origin.z,
                                          cone_origin.t);
                if (hist_count > 0)
                begin
                    lo = 0;
                    hi = hist_count;
                    while (hi - lo > 1)
                    begin
                        mid = (lo + hi) / 2;
                        probe = hist_mem[(hist_head + mid) % HIST_DEPTH];
                        if (in_past_cone(obs, probe.x, probe.y, probe.z, probe.t))
                        begin
                            lo = mid;
                        end
                        else
                        begin
                            hi = mid;
                        end
                    end
                    probe = hist_mem[(hist_head + lo) % HIST_DEPTH];
                    found.out_x      = probe.x;
                    found.out_y      = probe.y;
                    found.out_z      = probe.z;
                    found.out_time   = probe.t;
                    found.out_imp_x  = probe.imp_x;
                    found.out_imp_y  = probe.imp_y;
                    found.out_imp_z  = probe.imp_z;
                    found.out_proper = probe.proper;
                end
                pending_finds = {pending_finds, found};
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic lchs_cmd_t build_cmd(logic [1:0] act, int x, int y, int z, int t,
                                            int ix, int iy, int iz, int pt);
        lchs_cmd_t c;
        c.action      = act;
        c.pos_x       = x;
        c.pos_y       = y;
        c.pos_z       = z;
        c.frame_time  = t;
        c.imp_x       = ix;
        c.imp_y       = iy;
        c.imp_z       = iz;
        c.proper_time = pt;
        return c;
    endfunction

    function automatic lchs_cmd_t random_cmd(logic [1:0] act);
        return build_cmd(act, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Moves the body forward in time, normally slower than light with an occasional jump.
    function automatic void advance_track();
        int step, span;
        step = $urandom_range(1, 1 << 18);
        span = ($urandom_range(9) == 0) ? 2 * step : step / 2;
        tx += int'($urandom_range(0, 2 * span)) - span;
        ty += int'($urandom_range(0, 2 * span)) - span;
        tz += int'($urandom_range(0, 2 * span)) - span;
        tt += step;
    endfunction

    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    initial
    begin
        int issued;
        int r;
        cone_origin = '0;
        hist_head   = 0;
        hist_count  = 0;

        // Queries on the empty history, one inside and one outside the cone of the origin.
        queue_cmd(build_cmd(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN,
                            FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        // The very first push either stores the init event twice or an all-zero event first.
        if ($urandom_range(1) == 1)
        begin
            queue_cmd(build_cmd(ACT_INIT, ONE, 2 * ONE, 3 * ONE, 10 * ONE,
                                -ONE, 5, FIX_MAX, 7 * ONE));
        end
        else
        begin
            queue_cmd(build_cmd(ACT_APPEND, ONE, 2 * ONE, 3 * ONE, 10 * ONE,
                                -ONE, 5, FIX_MAX, 7 * ONE));
        end
        queue_cmd(build_cmd(ACT_QUERY, ONE, 2 * ONE, 3 * ONE, 20 * ONE,
                            0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, 0, 0, 0, 5 * ONE, 0, 0, 0, 0));
        // Start event exactly on the light cone surface, then just outside it.
        queue_cmd(build_cmd(ACT_INIT, 3 * ONE, 4 * ONE, 0, 0,
                            FIX_MIN, 0, 1, -1));
        queue_cmd(build_cmd(ACT_QUERY, 0, 0, 0, 5 * ONE, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, 0, 0, 0, 5 * ONE - 1, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_APPEND, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                            FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        queue_cmd(build_cmd(ACT_APPEND, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                            FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
        queue_cmd(build_cmd(ACT_APPEND, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        queue_cmd(build_cmd(ACT_QUERY, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX,
                            0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                            0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN,
                            0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, 0, 0, 0, FIX_MAX, 0, 0, 0, 0));
        queue_cmd(random_cmd(ACT_UNUSED));
        queue_cmd(build_cmd(ACT_UNUSED, FIX_MAX, FIX_MIN, 0, -1,
                            -1, -1, -1, -1));
        queue_cmd(build_cmd(ACT_INIT, FIX_MIN, FIX_MAX, -1, FIX_MAX,
                            0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_QUERY, FIX_MIN, FIX_MAX, -1, FIX_MAX,
                            FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        queue_cmd(random_cmd(ACT_QUERY));

        tx = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        ty = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        tz = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        tt = -int'($urandom_range(0, 1 << 30));
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                advance_track();
                queue_cmd(build_cmd(ACT_APPEND, tx, ty, tz, tt,
                                    $urandom, $urandom, $urandom, $urandom));
            end
            else if (r < 75)
            begin
                queue_cmd(build_cmd(ACT_QUERY,
                    tx + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                    ty + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                    tz + int'($urandom_range(0, 1 << 18)) - (1 << 17),
                    tt - int'($urandom_range(0, 1 << 23)) + int'($urandom_range(0, 1 << 16)),
                    $urandom, $urandom, $urandom, $urandom));
            end
            else if (r < 79)
            begin
                advance_track();
                queue_cmd(build_cmd(ACT_INIT, tx, ty, tz, tt,
                                    $urandom, $urandom, $urandom, $urandom));
            end
            else if (r < 82)
            begin
                queue_cmd(random_cmd(ACT_UNUSED));
                continue;
            end
            else if (r < 91)
            begin
                queue_cmd(random_cmd(($urandom_range(3) == 0) ? ACT_INIT : ACT_APPEND));
            end
            else
            begin
                queue_cmd(random_cmd(ACT_QUERY));
            end
            issued++;
        end

        while (command_queue.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (pending_finds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !cmd_taken)
            begin
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                cmd      <= random_cmd(2'($urandom_range(3)));
                gap_left <= gap_left - 1;
            end
            else if (command_queue.size() != 0)
            begin
                cmd      <= command_queue[0];
                command_queue.delete(0);
                start    <= 1'b1;
                gap_left <= next_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_finds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with no query waiting, expected none, got %h",
                             $time, result);
                end
                else
                begin
                    lchs_result_t want;
                    want = pending_finds[0];
                    pending_finds.delete(0);
                    check_field("seen", 32'(want.seen), 32'(result.seen));
                    check_field("out_x", want.out_x, result.out_x);
                    check_field("out_y", want.out_y, result.out_y);
                    check_field("out_z", want.out_z, result.out_z);
                    check_field("out_time", want.out_time, result.out_time);
                    check_field("out_imp_x", want.out_imp_x, result.out_imp_x);
                    check_field("out_imp_y", want.out_imp_y, result.out_imp_y);
                    check_field("out_imp_z", want.out_imp_z, result.out_imp_z);
                    check_field("out_proper", want.out_proper, result.out_proper);
                end
            end
            cmd_taken <= start && (busy === 1'b0);
            if (start && (busy === 1'b0))
            begin
                update_history_and_search(cmd);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== light_cone_history_search.f =====
hdl/lchs_pkg.sv
hdl/lchs_hist_mem.sv
hdl/lchs_cone.sv
hdl/light_cone_history_search.sv
dv/tb_light_cone_history_search.sv
